FILE: rtl/ems_pkg.sv
package ems_pkg;

	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;

	localparam logic [1:0] REG_QTURN_LEFT  = 2'd0;
	localparam logic [1:0] REG_QTURN_RIGHT = 2'd1;
	localparam logic [1:0] REG_DEF_TURN    = 2'd2;
	localparam logic [1:0] REG_CORR_LIMIT  = 2'd3;

	localparam logic [1:0] ACT_CMD  = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;

	localparam logic [2:0] KIND_IDLE    = 3'd0;
	localparam logic [2:0] KIND_FWD     = 3'd1;
	localparam logic [2:0] KIND_BACK    = 3'd2;
	localparam logic [2:0] KIND_TURN_L  = 3'd3;
	localparam logic [2:0] KIND_TURN_R  = 3'd4;
	localparam logic [2:0] KIND_QTURN_L = 3'd5;
	localparam logic [2:0] KIND_QTURN_R = 3'd6;
	localparam logic [2:0] KIND_BAD     = 3'd7;

	localparam logic [1:0] DRV_STOP = 2'd0;
	localparam logic [1:0] DRV_FWD  = 2'd1;
	localparam logic [1:0] DRV_BACK = 2'd2;

	typedef struct packed {
		logic [14:0] qturn_left;
		logic [14:0] qturn_right;
		logic [14:0] def_turn;
		logic [7:0]  corr_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         move_kind;
		logic signed [15:0] left_target;
		logic signed [15:0] right_target;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] start_left;
		logic [31:0] start_right;
		logic signed [15:0] goal_left;
		logic signed [15:0] goal_right;
		logic [1:0]  drive_left;
		logic [1:0]  drive_right;
		logic [7:0]  correction;
	} state_t;

	typedef struct packed {
		logic [1:0] left_drive;
		logic [1:0] right_drive;
		logic [7:0] left_correction;
		logic       busy_res;
		logic       was_idle;
	} res_t;

endpackage

FILE: rtl/ems_step.sv
module ems_step (
	input  ems_pkg::cfg_t   cfg,
	input  ems_pkg::state_t st,
	input  ems_pkg::item_t  item,
	output ems_pkg::state_t st_nxt,
	output ems_pkg::res_t   res
);
	import ems_pkg::*;

	logic signed [31:0] dist_l;
	logic signed [31:0] dist_r;
	logic signed [32:0] drift;
	logic signed [31:0] tgt_l;
	logic signed [31:0] tgt_r;
	logic [1:0]         dir_l;
	logic [1:0]         dir_r;
	logic               done_l;
	logic               done_r;
	logic               idle_seen;
	logic signed [31:0] turn_l;
	logic signed [31:0] turn_r;
	logic signed [31:0] def_turn;

	assign dist_l   = $signed(item.left_count - st.start_left);
	assign dist_r   = $signed(item.right_count - st.start_right);
	assign drift    = {dist_l[31], dist_l} - {dist_r[31], dist_r};
	assign def_turn = $signed({17'd0, cfg.def_turn});
	assign turn_l   = (st.goal_left > 16'sd2) ? 32'(st.goal_left) : def_turn;
	assign turn_r   = (st.goal_right > 16'sd2) ? 32'(st.goal_right) : def_turn;

	always_comb begin
		tgt_l = 32'(st.goal_left);
		tgt_r = 32'(st.goal_right);
		dir_l = DRV_FWD;
		dir_r = DRV_FWD;
		case (st.mode)
			KIND_BACK: begin
				dir_l = DRV_BACK;
				dir_r = DRV_BACK;
			end
			KIND_TURN_L: begin
				tgt_l = turn_l;
				tgt_r = turn_l;
				dir_l = DRV_BACK;
			end
			KIND_TURN_R: begin
				tgt_l = turn_r;
				tgt_r = turn_r;
				dir_r = DRV_BACK;
			end
			KIND_QTURN_L: begin
				tgt_l = $signed({17'd0, cfg.qturn_left});
				tgt_r = $signed({17'd0, cfg.qturn_right});
				dir_l = DRV_BACK;
			end
			KIND_QTURN_R: begin
				tgt_l = $signed({17'd0, cfg.qturn_left});
				tgt_r = $signed({17'd0, cfg.qturn_right});
				dir_r = DRV_BACK;
			end
			default: begin
			end
		endcase
	end

	assign done_l = dist_l >= tgt_l;
	assign done_r = dist_r >= tgt_r;

	always_comb begin
		st_nxt    = st;
		idle_seen = 1'b0;
		case (item.action)
			ACT_CMD: begin
				if (item.move_kind == KIND_IDLE) begin
					st_nxt.drive_left  = DRV_STOP;
					st_nxt.drive_right = DRV_STOP;
					st_nxt.mode        = KIND_IDLE;
				end else if (item.move_kind != KIND_BAD) begin
					st_nxt.start_left  = item.left_count;
					st_nxt.start_right = item.right_count;
					if (item.move_kind == KIND_FWD || item.move_kind == KIND_BACK ||
					    item.move_kind == KIND_TURN_L)
						st_nxt.goal_left = item.left_target;
					if (item.move_kind == KIND_FWD || item.move_kind == KIND_BACK ||
					    item.move_kind == KIND_TURN_R)
						st_nxt.goal_right = item.right_target;
					st_nxt.mode = item.move_kind;
				end
			end
			ACT_TICK: begin
				if (st.mode == KIND_IDLE) begin
					idle_seen = 1'b1;
				end else if (st.mode != KIND_BAD) begin
					if (st.mode == KIND_FWD || st.mode == KIND_BACK) begin
						if (drift > 33'sd1 && st.correction != 8'd0)
							st_nxt.correction = st.correction - 8'd1;
						else if (drift < -33'sd1 && st.correction < cfg.corr_limit)
							st_nxt.correction = st.correction + 8'd1;
					end
					st_nxt.drive_left  = done_l ? DRV_STOP : dir_l;
					st_nxt.drive_right = done_r ? DRV_STOP : dir_r;
					if (done_l && done_r)
						st_nxt.mode = KIND_IDLE;
				end
			end
			ACT_STOP: begin
				st_nxt.drive_left  = DRV_STOP;
				st_nxt.drive_right = DRV_STOP;
			end
			default: begin
			end
		endcase
	end

	assign res.left_drive      = st_nxt.drive_left;
	assign res.right_drive     = st_nxt.drive_right;
	assign res.left_correction = st_nxt.correction;
	assign res.busy_res        = st_nxt.mode != KIND_IDLE;
	assign res.was_idle        = idle_seen;

endmodule

FILE: rtl/encoder_move_sequencer.sv
// Channel  | Handshake                | Payload
// input    | in_valid / in_stall      | action, move_kind, left/right_target, left/right_count
// output   | out_valid / out_stall    | left/right_drive, left_correction, busy_res, was_idle
// config   | psel, penable, pwrite    | paddr, pwdata, prdata (pready tied high)
// One beat in, one beat out; a taken beat waits in the input register until the result register has room.
// A new beat is taken every cycle unless the output is stalled; the move state is fed back around one stage.
// Reset puts the move state to idle, drives to stop, correction to zero, registers to defaults.
// A stalled output holds its beat; the input register still takes one more beat behind it.
module encoder_move_sequencer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic [2:0]                move_kind,
	input  logic signed [15:0]        left_target,
	input  logic signed [15:0]        right_target,
	input  logic signed [31:0]        left_count,
	input  logic signed [31:0]        right_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                left_drive,
	output logic [1:0]                right_drive,
	output logic [7:0]                left_correction,
	output logic                      busy_res,
	output logic                      was_idle,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ems_pkg::AddrW-1:0] paddr,
	input  logic [ems_pkg::DataW-1:0] pwdata,
	output logic [ems_pkg::DataW-1:0] prdata,
	output logic                      pready
);
	import ems_pkg::*;

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nxt;
	item_t  item_s1;
	logic   valid_s1;
	res_t   res_nxt;
	res_t   res_s2;
	logic   valid_s2;
	logic   adv;
	logic   take;
	logic   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qturn_left  <= 15'd100;
			cfg_q.qturn_right <= 15'd100;
			cfg_q.def_turn    <= 15'd100;
			cfg_q.corr_limit  <= 8'd255;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_QTURN_LEFT:  cfg_q.qturn_left  <= pwdata[14:0];
				REG_QTURN_RIGHT: cfg_q.qturn_right <= pwdata[14:0];
				REG_DEF_TURN:    cfg_q.def_turn    <= pwdata[14:0];
				REG_CORR_LIMIT:  cfg_q.corr_limit  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_QTURN_LEFT:  prdata = {17'd0, cfg_q.qturn_left};
			REG_QTURN_RIGHT: prdata = {17'd0, cfg_q.qturn_right};
			REG_DEF_TURN:    prdata = {17'd0, cfg_q.def_turn};
			REG_CORR_LIMIT:  prdata = {24'd0, cfg_q.corr_limit};
			default:         prdata = '0;
		endcase
	end

	// advance the input register into the result register when it has room
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action       <= action;
			item_s1.move_kind    <= move_kind;
			item_s1.left_target  <= left_target;
			item_s1.right_target <= right_target;
			item_s1.left_count   <= left_count;
			item_s1.right_count  <= right_count;
		end
	end

	ems_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= KIND_IDLE;
			st_q.start_left  <= '0;
			st_q.start_right <= '0;
			st_q.goal_left   <= '0;
			st_q.goal_right  <= '0;
			st_q.drive_left  <= DRV_STOP;
			st_q.drive_right <= DRV_STOP;
			st_q.correction  <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (~out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign out_valid       = valid_s2;
	assign left_drive      = res_s2.left_drive;
	assign right_drive     = res_s2.right_drive;
	assign left_correction = res_s2.left_correction;
	assign busy_res        = res_s2.busy_res;
	assign was_idle        = res_s2.was_idle;

endmodule

FILE: rtl/ems_checker.sv
module ems_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] left_drive,
	input logic [1:0] right_drive,
	input logic       busy_res,
	input logic       was_idle
);
	import ems_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_drive) && $stable(right_drive) &&
		$stable(busy_res) && $stable(was_idle))
		else $error("stalled output beat changed");

	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> left_drive == DRV_STOP && right_drive == DRV_STOP)
		else $error("wheel driven while idle");

	a_drive_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_drive != 2'd3 && right_drive != 2'd3)
		else $error("illegal drive code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind encoder_move_sequencer ems_checker u_ems_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.busy_res    (busy_res),
	.was_idle    (was_idle)
);
